// ----- sv/lksm_pkg.sv -----
// Shared types, register indexes, opcodes and defaults of the leader-key matcher.
package lksm_pkg;

    localparam int MAX_SEQ_LEN_DEF  = 4;
    localparam int DICT_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF     = 16;

    localparam int FIELD_W   = 16;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH = 2'd2;

    localparam logic [1:0] OP_KEY        = 2'd0;
    localparam logic [1:0] OP_TICK       = 2'd1;
    localparam logic [1:0] OP_DICT_WRITE = 2'd2;

    localparam logic [FIELD_W-1:0] TIMEOUT_RESET     = 16'd1000;
    localparam logic [FIELD_W-1:0] LEADER_LOW_RESET  = 16'hFFFF;
    localparam logic [FIELD_W-1:0] LEADER_HIGH_RESET = 16'h0000;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_TICK,
        CMD_IDLE_EVT,
        CMD_KEY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [FIELD_W-1:0] key;
        logic               leader;
        logic               now;
        logic               prev;
        logic [3:0]         entry;
        logic [2:0]         slot;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- sv/leader_key_sequence_matcher_top.sv -----
// Top level of the leader-key sequence matcher: config registers, front, queue, back.
// A write, tick, idle or held event passes the front register and the queue, and its result is registered.
// A lookup (press or release in an active sequence) walks the dictionary one key slot read at a time,
// each read passing the read and check states, with at most DICT_ENTRIES*(MAX_SEQ_LEN+2) reads.
// Throughput: one request at a time; busy stays high until the back end is idle again.
// Reset: asynchronous, clears sequence state and dictionary valid bits at once, no sweep.
// Results show for one cycle on done; the receiver cannot stall them.
module leader_key_sequence_matcher_top
    import lksm_pkg::*;
#(
    parameter int MAX_SEQ_LEN  = MAX_SEQ_LEN_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [FIELD_W-1:0]   key_code,
    input  logic                 pressed_now,
    input  logic                 pressed_before,
    input  logic                 injected,
    input  logic [3:0]           entry_index,
    input  logic [2:0]           key_slot,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    output logic                 done,
    output logic                 consumed,
    output logic                 fire,
    output logic [3:0]           fire_entry
);

    logic [FIELD_W-1:0] timeout_reg, leader_low_reg, leader_high_reg;
    logic               accept;
    logic               front_pending;
    logic               push;
    cmd_t               push_cmd;
    logic               pop;
    cmd_t               pop_cmd;
    q_status_t          q_status;
    logic               back_busy;

    // a request is taken only when nothing is in flight anywhere
    assign busy   = front_pending || !q_status.empty || back_busy;
    assign accept = start && !busy;

    // configuration writes land directly; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            leader_low_reg  <= LEADER_LOW_RESET;
            leader_high_reg <= LEADER_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT:     timeout_reg     <= cfg_data;
                REG_LEADER_LOW:  leader_low_reg  <= cfg_data;
                REG_LEADER_HIGH: leader_high_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // front end: hold the request and classify it
    lksm_front #(
        .MAX_SEQ_LEN  (MAX_SEQ_LEN),
        .DICT_ENTRIES (DICT_ENTRIES),
        .KEY_BITS     (KEY_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .op             (op),
        .key_code       (key_code),
        .pressed_now    (pressed_now),
        .pressed_before (pressed_before),
        .injected       (injected),
        .entry_index    (entry_index),
        .key_slot       (key_slot),
        .leader_low     (leader_low_reg),
        .leader_high    (leader_high_reg),
        .q_status       (q_status),
        .pending        (front_pending),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // decoupling queue
    lksm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // back end: advance sequence state, run dictionary lookups, drive results
    lksm_back #(
        .MAX_SEQ_LEN  (MAX_SEQ_LEN),
        .DICT_ENTRIES (DICT_ENTRIES),
        .KEY_BITS     (KEY_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .q_status      (q_status),
        .cmd           (pop_cmd),
        .pop           (pop),
        .busy          (back_busy),
        .done          (done),
        .consumed      (consumed),
        .fire          (fire),
        .fire_entry    (fire_entry)
    );

endmodule

// ----- sv/lksm_front.sv -----
// Front end: captures a request and classifies it into a command.
module lksm_front
    import lksm_pkg::*;
#(
    parameter int MAX_SEQ_LEN  = MAX_SEQ_LEN_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         op,
    input  logic [FIELD_W-1:0] key_code,
    input  logic               pressed_now,
    input  logic               pressed_before,
    input  logic               injected,
    input  logic [3:0]         entry_index,
    input  logic [2:0]         key_slot,
    input  logic [FIELD_W-1:0] leader_low,
    input  logic [FIELD_W-1:0] leader_high,
    input  q_status_t          q_status,
    output logic               pending,
    output logic               push,
    output cmd_t               push_cmd
);

    localparam int SLOTS = MAX_SEQ_LEN + 2;
    localparam logic [FIELD_W-1:0] KEY_MASK = FIELD_W'((17'd1 << KEY_BITS) - 17'd1);

    logic               valid_reg, valid_next;
    cmd_t               cmd_reg;
    cmd_t               cls;
    logic [FIELD_W-1:0] key_m;

    always_comb
    begin
        key_m      = key_code & KEY_MASK;
        cls.key    = key_m;
        cls.leader = (key_m >= leader_low) && (key_m <= leader_high);
        cls.now    = pressed_now;
        cls.prev   = pressed_before;
        cls.entry  = entry_index;
        cls.slot   = key_slot;
        case (op)
            OP_DICT_WRITE:
                cls.kind = ((32'(entry_index) < DICT_ENTRIES) && (32'(key_slot) < SLOTS))
                           ? CMD_WRITE : CMD_NONE;
            OP_TICK:
                cls.kind = CMD_TICK;
            OP_KEY:
                if (injected)
                    cls.kind = CMD_NONE;
                else if (!pressed_now && !pressed_before)
                    cls.kind = CMD_IDLE_EVT;
                else
                    cls.kind = CMD_KEY;
            default:
                cls.kind = CMD_NONE;
        endcase
    end

    assign push     = valid_reg && !q_status.full;
    assign push_cmd = cmd_reg;
    assign pending  = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cls;
    end

endmodule

// ----- sv/lksm_queue.sv -----
// Two-entry command queue between the front end and the sequencer.
module lksm_queue
    import lksm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    cmd_t       slots_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign pop_cmd      = slots_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue pop while empty");

endmodule

// ----- sv/lksm_back.sv -----
// Back end: sequence state, dictionary memory and the lookup sequencer.
module lksm_back
    import lksm_pkg::*;
#(
    parameter int MAX_SEQ_LEN  = MAX_SEQ_LEN_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FIELD_W-1:0] timeout_ticks,
    input  q_status_t          q_status,
    input  cmd_t               cmd,
    output logic               pop,
    output logic               busy,
    output logic               done,
    output logic               consumed,
    output logic               fire,
    output logic [3:0]         fire_entry
);

    localparam int SLOTS  = MAX_SEQ_LEN + 2;
    localparam int DEPTH  = DICT_ENTRIES * SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TK_W   = $clog2(MAX_SEQ_LEN + 1);
    localparam int E_W    = $clog2(DICT_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_CK   = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [KEY_BITS-1:0] tk_reg [MAX_SEQ_LEN+1];
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [FIELD_W-1:0]  tl_reg, tl_next, tl_dec;
    logic [E_W-1:0]      e_reg, e_next;
    logic [SLOT_W-1:0]   i_reg, i_next;
    logic                rel_reg, rel_next;
    logic                done_reg, done_next;
    logic                cons_reg, cons_next;
    logic                fire_reg, fire_next;
    logic [3:0]          act_reg, act_next;

    logic                tk_we;
    logic [TK_W-1:0]     tk_widx;
    logic [KEY_BITS-1:0] tk_wdata;

    logic [KEY_BITS-1:0] mem [DEPTH];
    logic                vld_reg [DEPTH];
    logic [KEY_BITS-1:0] rdata_reg;
    logic                rvld_reg;
    logic                we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [KEY_BITS-1:0] d;
    logic                active;

    assign active = (tk_reg[0] != '0);
    assign d      = rvld_reg ? rdata_reg : '0;
    assign pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign busy   = (state_reg != ST_IDLE);
    assign waddr  = ADDR_W'(32'(cmd.entry) * SLOTS + 32'(cmd.slot));
    assign raddr  = ADDR_W'(32'(e_reg) * SLOTS + 32'(i_reg));

    assign done       = done_reg;
    assign consumed   = cons_reg;
    assign fire       = fire_reg;
    assign fire_entry = act_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        tl_next    = tl_reg;
        e_next     = e_reg;
        i_next     = i_reg;
        rel_next   = rel_reg;
        done_next  = 1'b0;
        cons_next  = 1'b0;
        fire_next  = 1'b0;
        act_next   = 4'd0;
        tk_we      = 1'b0;
        tk_widx    = '0;
        tk_wdata   = '0;
        we         = 1'b0;
        tl_dec     = (tl_reg != '0) ? tl_reg - 16'd1 : '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (cmd.kind)
                        CMD_WRITE:
                        begin
                            we        = 1'b1;
                            done_next = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            done_next = 1'b1;
                            if (active)
                            begin
                                tl_next = tl_dec;
                                if (tl_dec == '0)
                                begin
                                    // timeout expired: drop the sequence
                                    pos_next = '0;
                                    tk_we    = 1'b1;
                                end
                            end
                        end
                        CMD_IDLE_EVT:
                        begin
                            done_next = 1'b1;
                            cons_next = cmd.leader;
                        end
                        CMD_KEY:
                        begin
                            if (!active)
                            begin
                                done_next = 1'b1;
                                cons_next = cmd.leader;
                                if (cmd.leader && !cmd.now && cmd.prev)
                                begin
                                    tl_next  = timeout_ticks;
                                    pos_next = '0;
                                    tk_we    = 1'b1;
                                    tk_wdata = KEY_BITS'(cmd.key);
                                end
                            end
                            else if (cmd.now && !cmd.prev)
                            begin
                                if (pos_reg == SLOT_W'(MAX_SEQ_LEN))
                                begin
                                    // overlong: drop and pass the press on
                                    done_next = 1'b1;
                                    pos_next  = '0;
                                    tk_we     = 1'b1;
                                end
                                else
                                begin
                                    pos_next   = pos_reg + 1'b1;
                                    tl_next    = timeout_ticks;
                                    tk_we      = 1'b1;
                                    tk_widx    = TK_W'(pos_reg + 1'b1);
                                    tk_wdata   = KEY_BITS'(cmd.key);
                                    rel_next   = 1'b0;
                                    e_next     = '0;
                                    i_next     = '0;
                                    state_next = ST_RD;
                                end
                            end
                            else if (cmd.now)
                            begin
                                done_next = 1'b1;
                                cons_next = 1'b1;
                            end
                            else
                            begin
                                rel_next   = 1'b1;
                                e_next     = '0;
                                i_next     = '0;
                                state_next = ST_RD;
                            end
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            ST_RD:
                state_next = ST_CK;
            ST_CK:
            begin
                if ((i_reg == '0) && (d == '0))
                begin
                    // end of dictionary: no match
                    done_next  = 1'b1;
                    pos_next   = '0;
                    tk_we      = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (i_reg <= pos_reg)
                begin
                    if (d == tk_reg[i_reg[TK_W-1:0]])
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_RD;
                    end
                    else if (e_reg == E_W'(DICT_ENTRIES - 1))
                    begin
                        done_next  = 1'b1;
                        pos_next   = '0;
                        tk_we      = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        i_next     = '0;
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    // prefix matched; the next slot tells full from partial
                    done_next  = 1'b1;
                    cons_next  = 1'b1;
                    state_next = ST_IDLE;
                    if ((d == '0) && rel_reg)
                    begin
                        fire_next = 1'b1;
                        act_next  = 4'(e_reg);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            tl_reg    <= '0;
            done_reg  <= 1'b0;
            cons_reg  <= 1'b0;
            fire_reg  <= 1'b0;
            act_reg   <= 4'd0;
            for (int k = 0; k <= MAX_SEQ_LEN; k++)
                tk_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            tl_reg    <= tl_next;
            done_reg  <= done_next;
            cons_reg  <= cons_next;
            fire_reg  <= fire_next;
            act_reg   <= act_next;
            if (tk_we)
                tk_reg[tk_widx] <= tk_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        i_reg   <= i_next;
        rel_reg <= rel_next;
    end

    // dictionary store; per-slot valid bits give the cleared state at reset
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= KEY_BITS'(cmd.key);
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg <= 1'b0;
            for (int k = 0; k < DEPTH; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            rvld_reg <= vld_reg[raddr] && !(we && (waddr == raddr));
            if (we)
                vld_reg[waddr] <= 1'b1;
        end
    end

    a_fire_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && fire_reg) |-> cons_reg)
        else $error("fire without consume");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= SLOT_W'(MAX_SEQ_LEN))
        else $error("typed position out of range");

    a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_CK))
        else $error("memory read not followed by check");

endmodule
